// ----- src/msp_pkg.sv -----
// Shared types and constants for the multi-channel servo pulse generator.
`timescale 1ns / 1ps
`default_nettype none
package msp_pkg;

	localparam int NUM_CHANNELS = 32;
	localparam int WIDTH_BITS   = 16;
	localparam int CHAN_BITS    = 5;
	localparam int PIN_BITS     = 32;

	localparam logic [WIDTH_BITS-1:0] FRAME_TICKS_RESET = WIDTH_BITS'(3125);

	// configuration register map (byte offset bit 2 selects the register)
	localparam int APB_ADDR_BITS = 3;
	localparam logic REG_FRAME_TICKS = 1'b0;

	// item queue between front and back
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = 2;
	localparam int QUEUE_CNT_BITS = 3;

	// input item selector carried on tuser
	typedef enum logic {
		FUNC_TICK = 1'b0,
		FUNC_SET  = 1'b1
	} func_t;

	// classified command as seen by the back end
	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_SET,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [CHAN_BITS-1:0]  channel;
		logic [WIDTH_BITS-1:0] width;
	} cmd_t;

endpackage
`default_nettype wire

// ----- src/msp_front.sv -----
// Front end: registers incoming items and classifies them into commands.
`timescale 1ns / 1ps
`default_nettype none
module msp_front (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [23:0]                        s_tdata,
	input  wire                                s_tuser,
	output logic                               q_valid,
	input  wire                                q_ready,
	output msp_pkg::cmd_t                      q_cmd
);

	logic          valid_s1;
	msp_pkg::cmd_t cmd_s1;
	msp_pkg::cmd_t cmd_in;
	logic          in_range;

	assign s_tready = !valid_s1 || q_ready;

	// a set-width item for a channel that does not exist still yields a result
	assign in_range = {1'b0, s_tdata[msp_pkg::CHAN_BITS-1:0]}
		< (msp_pkg::CHAN_BITS+1)'(msp_pkg::NUM_CHANNELS);

	always_comb begin
		cmd_in.channel = s_tdata[msp_pkg::CHAN_BITS-1:0];
		cmd_in.width   = s_tdata[msp_pkg::CHAN_BITS +: msp_pkg::WIDTH_BITS];
		case (msp_pkg::func_t'(s_tuser))
			msp_pkg::FUNC_TICK: cmd_in.kind = msp_pkg::KIND_TICK;
			msp_pkg::FUNC_SET:  cmd_in.kind = in_range ? msp_pkg::KIND_SET : msp_pkg::KIND_NOP;
			default:            cmd_in.kind = msp_pkg::KIND_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= cmd_in;
		end
	end

	assign q_valid = valid_s1;
	assign q_cmd   = cmd_s1;

endmodule
`default_nettype wire

// ----- src/msp_queue.sv -----
// Short command queue decoupling the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none
module msp_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  msp_pkg::cmd_t  in_cmd,
	output logic           out_valid,
	input  wire            out_ready,
	output msp_pkg::cmd_t  out_cmd
);

	msp_pkg::cmd_t                      mem_q [msp_pkg::QUEUE_DEPTH];
	logic [msp_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [msp_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [msp_pkg::QUEUE_CNT_BITS-1:0] count_q;
	logic                               push;
	logic                               pop;

	assign in_ready  = count_q != msp_pkg::QUEUE_CNT_BITS'(msp_pkg::QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule
`default_nettype wire

// ----- src/msp_back.sv -----
// Back end: frame counter, per-channel width compares and the result register.
`timescale 1ns / 1ps
`default_nettype none
module msp_back (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire  [msp_pkg::WIDTH_BITS-1:0]       frame_ticks,
	input  wire                                  q_valid,
	output logic                                 q_ready,
	input  msp_pkg::cmd_t                        q_cmd,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [msp_pkg::PIN_BITS-1:0]         m_tdata
);

	logic [msp_pkg::WIDTH_BITS-1:0]   fc_q;
	logic [msp_pkg::WIDTH_BITS-1:0]   act_q    [msp_pkg::NUM_CHANNELS];
	logic [msp_pkg::WIDTH_BITS-1:0]   staged_q [msp_pkg::NUM_CHANNELS];
	logic [msp_pkg::WIDTH_BITS-1:0]   act_new  [msp_pkg::NUM_CHANNELS];
	logic [msp_pkg::NUM_CHANNELS-1:0] sv_q;
	logic [msp_pkg::NUM_CHANNELS-1:0] level_q;
	logic [msp_pkg::NUM_CHANNELS-1:0] level_new;
	logic [msp_pkg::NUM_CHANNELS-1:0] zero_mask;
	logic [msp_pkg::WIDTH_BITS-1:0]   fc_inc;
	logic [msp_pkg::WIDTH_BITS-1:0]   fc_next;
	logic                             start;
	logic                             pop;
	logic                             tick;
	logic                             set;
	logic                             m_tvalid_q;
	logic [msp_pkg::PIN_BITS-1:0]     m_tdata_q;

	assign q_ready = !m_tvalid_q || m_tready;
	assign pop     = q_valid && q_ready;
	assign tick    = pop && (q_cmd.kind == msp_pkg::KIND_TICK);
	assign set     = pop && (q_cmd.kind == msp_pkg::KIND_SET);

	// wrap when the next count meets the frame length, or when the length was lowered
	assign fc_inc  = fc_q + 1'b1;
	assign fc_next = (fc_inc >= frame_ticks || fc_q >= frame_ticks) ? '0 : fc_inc;
	assign start   = fc_next == '0;

	always_comb begin
		for (int i = 0; i < msp_pkg::NUM_CHANNELS; i++) begin
			act_new[i]   = (start && sv_q[i]) ? staged_q[i] : act_q[i];
			level_new[i] = (start ? (act_new[i] != '0) : level_q[i])
				&& !(fc_next >= act_new[i]);
			zero_mask[i] = act_q[i] == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q       <= '0;
			sv_q       <= '0;
			level_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < msp_pkg::NUM_CHANNELS; i++) begin
				act_q[i] <= '0;
			end
		end else begin
			if (tick) begin
				fc_q    <= fc_next;
				level_q <= level_new;
				if (start) begin
					sv_q <= '0;
					for (int i = 0; i < msp_pkg::NUM_CHANNELS; i++) begin
						act_q[i] <= act_new[i];
					end
				end
			end else if (set) begin
				sv_q[q_cmd.channel] <= 1'b1;
			end
			if (pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (set) begin
			staged_q[q_cmd.channel] <= q_cmd.width;
		end
		if (pop) begin
			m_tdata_q <= msp_pkg::PIN_BITS'(tick ? level_new : level_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	a_zero_width_low: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q & zero_mask) == '0)
		else $error("channel with zero active width is high");

	a_set_keeps_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_cmd.kind != msp_pkg::KIND_TICK) |=> m_tdata_q == $past(level_q))
		else $error("non-tick item changed the pin mask");

	a_count_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> (fc_q < $past(frame_ticks) || fc_q == '0))
		else $error("frame counter left the frame");
`endif

endmodule
`default_nettype wire

// ----- src/multi_servo_pulse_generator_top.sv -----
// Top level of the multi-channel servo pulse generator.
//
// Usage:
//   Items enter on the s_ stream. s_tuser selects the kind: a timer tick or a
//   set-width item that stages a new pulse width for one channel. Every item
//   yields exactly one result on the m_ stream: the 32-bit pin-level mask
//   after the item has taken effect.
//   The front end registers and classifies each item, a four-entry queue
//   holds commands, and the back end updates the frame counter and runs all
//   32 width compares in parallel, so one item is taken every cycle unless
//   the receiver stalls. An item passes through the front register, the queue
//   and the result register in that order; sustained throughput is one item
//   per cycle when the output side is not stalled.
//   When the receiver stalls, the result register holds, the back end stops
//   popping, and the queue and front register absorb further items until
//   s_tready drops.
//   Reset clears the counter, all active widths, staged flags and pins (all low);
//   frame_ticks returns to 3125. Pins stay low until the first frame start.
//   The user must write frame_ticks via APB offset 0 only while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none
module multi_servo_pulse_generator_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// APB configuration port
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [msp_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  wire  [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// input items
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [23:0]                         s_tdata,  // channel[4:0], pulse_ticks[20:5], zero pad
	input  wire                                 s_tuser,  // func
	// results
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [msp_pkg::PIN_BITS-1:0]        m_tdata   // pin_levels[31:0]
);

	logic [msp_pkg::WIDTH_BITS-1:0] frame_ticks_q;
	logic                           cfg_write;
	logic                           fq_valid;
	logic                           fq_ready;
	msp_pkg::cmd_t                  fq_cmd;
	logic                           qb_valid;
	logic                           qb_ready;
	msp_pkg::cmd_t                  qb_cmd;

	// APB: no wait states; bit 2 of the byte address picks the register
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr[2] == msp_pkg::REG_FRAME_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ticks_q <= msp_pkg::FRAME_TICKS_RESET;
		end else if (cfg_write) begin
			frame_ticks_q <= pwdata[msp_pkg::WIDTH_BITS-1:0];
		end
	end

	// read back the frame length; other offsets read as zero
	assign prdata = (paddr[2] == msp_pkg::REG_FRAME_TICKS)
		? 32'(frame_ticks_q) : 32'd0;

	msp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_cmd    (fq_cmd)
	);

	msp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_cmd    (fq_cmd),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_cmd   (qb_cmd)
	);

	msp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_ticks (frame_ticks_q),
		.q_valid     (qb_valid),
		.q_ready     (qb_ready),
		.q_cmd       (qb_cmd),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule
`default_nettype wire
